@@ rtl/ctf_pkg.sv @@
// Shared types, constants and plane helpers for the frustum triangle clipper.
`default_nettype none

package ctf_pkg;

    localparam int MAX_POLY_VERTICES = 9;
    localparam int CNT_W             = $clog2(MAX_POLY_VERTICES + 1);
    localparam int IDX_W             = $clog2(MAX_POLY_VERTICES);
    localparam int PLANE_COUNT       = 6;
    localparam int MIN_POLY          = 3;
    localparam int FRAC_BITS         = 16;
    localparam int DIV_STEPS         = FRAC_BITS + 1;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;
    localparam logic [1:0] COORD_W = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_vtx;

    typedef struct packed {
        t_vtx vtx;
        logic is_end;
        logic drop;
    } t_beat;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] aw;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] bw;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } t_tri_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [1:0]         corner;
        logic               last_of_run;
    } t_vtx_out;

    function automatic logic signed [31:0] vtx_coord(input t_vtx v, input logic [1:0] k);
        logic signed [31:0] c;
        case (k)
            COORD_X: c = v.x;
            COORD_Y: c = v.y;
            COORD_Z: c = v.z;
            default: c = v.w;
        endcase
        return c;
    endfunction

    // Even planes: c + w, odd planes: c - w, exact at 33 bits.
    function automatic logic signed [32:0] plane_fn(input t_vtx v, input logic [2:0] p);
        logic signed [31:0] c;
        logic signed [32:0] f;
        c = vtx_coord(v, p[2:1]);
        if (p[0] == 1'b0) begin
            f = {c[31], c} + {v.w[31], v.w};
        end else begin
            f = {c[31], c} - {v.w[31], v.w};
        end
        return f;
    endfunction

    function automatic logic plane_inside(input t_vtx v, input logic [2:0] p);
        logic signed [32:0] f;
        f = plane_fn(v, p);
        if (p[0] == 1'b0) begin
            return !f[32];
        end
        return f[32] || (f == 33'sd0);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ctf_plane_cell.sv @@
// One Sutherland-Hodgman plane stage: streams a polygon in, streams the clipped one out.
`default_nettype none

module ctf_plane_cell import ctf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_plane,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_beat      i_beat,
    output logic       o_valid,
    input  logic       i_stall,
    output t_beat      o_beat
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PREP     = 3'd1;
    localparam logic [2:0] ST_DIV      = 3'd2;
    localparam logic [2:0] ST_MUL      = 3'd3;
    localparam logic [2:0] ST_ADD      = 3'd4;
    localparam logic [2:0] ST_EMIT_P   = 3'd5;
    localparam logic [2:0] ST_EMIT_B   = 3'd6;
    localparam logic [2:0] ST_EMIT_END = 3'd7;

    logic [2:0]         r_state, n_state;
    logic               r_have_first, n_have_first;
    t_vtx               r_first, n_first;
    t_vtx               r_prev, n_prev;
    t_vtx               r_a, n_a;
    t_vtx               r_b, n_b;
    t_vtx               r_p, n_p;
    logic               r_closing, n_closing;
    logic               r_drop_in, n_drop_in;
    logic [CNT_W-1:0]   r_cnt_out, n_cnt_out;
    logic               r_ia, n_ia;
    logic               r_ib, n_ib;
    logic [34:0]        r_rem, n_rem;
    logic [16:0]        r_num, n_num;
    logic [34:0]        r_den, n_den;
    logic [16:0]        r_q, n_q;
    logic [4:0]         r_step, n_step;
    logic [1:0]         r_k, n_k;
    logic signed [50:0] r_prod, n_prod;
    logic               r_ovalid, n_ovalid;
    t_beat              r_obeat, n_obeat;

    logic               slot_free;
    logic               ia, ib;
    logic signed [32:0] fa, fb;
    logic [32:0]        abs_fa;
    logic signed [34:0] den35;
    logic [34:0]        abs_den;
    logic [35:0]        trial;
    logic               ge;
    logic [16:0]        t_val;
    logic signed [31:0] a_k, b_k;
    logic signed [32:0] diff;
    logic signed [50:0] mul;
    logic signed [50:0] adj;
    logic signed [50:0] shq;
    logic signed [31:0] sum;
    logic [2:0]         fin_state;

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_beat  = r_obeat;

    always_comb begin
        slot_free = !r_ovalid || !i_stall;
        fa        = plane_fn(r_a, i_plane);
        fb        = plane_fn(r_b, i_plane);
        ia        = plane_inside(r_a, i_plane);
        ib        = plane_inside(r_b, i_plane);
        abs_fa    = fa[32] ? 33'(-fa) : 33'(fa);
        den35     = {{2{fa[32]}}, fa} - {{2{fb[32]}}, fb};
        abs_den   = den35[34] ? 35'(-den35) : 35'(den35);
        trial     = {r_rem, r_num[16]};
        ge        = (trial >= {1'b0, r_den});
        t_val     = (r_den == '0) ? '0 : r_q;
        a_k       = vtx_coord(r_a, r_k);
        b_k       = vtx_coord(r_b, r_k);
        diff      = {b_k[31], b_k} - {a_k[31], a_k};
        mul       = diff * $signed({1'b0, t_val});
        adj       = r_prod[50] ? (r_prod + 51'sd65535) : r_prod;
        shq       = adj >>> FRAC_BITS;
        sum       = a_k + shq[31:0];
        fin_state = r_closing ? ST_EMIT_END : ST_IDLE;
    end

    always_comb begin
        n_state      = r_state;
        n_have_first = r_have_first;
        n_first      = r_first;
        n_prev       = r_prev;
        n_a          = r_a;
        n_b          = r_b;
        n_p          = r_p;
        n_closing    = r_closing;
        n_drop_in    = r_drop_in;
        n_cnt_out    = r_cnt_out;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_rem        = r_rem;
        n_num        = r_num;
        n_den        = r_den;
        n_q          = r_q;
        n_step       = r_step;
        n_k          = r_k;
        n_prod       = r_prod;
        n_ovalid     = r_ovalid && i_stall;
        n_obeat      = r_obeat;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_beat.is_end) begin
                        n_drop_in = i_beat.drop;
                        if (r_have_first) begin
                            n_a       = r_prev;
                            n_b       = r_first;
                            n_closing = 1'b1;
                            n_state   = ST_PREP;
                        end else begin
                            n_state = ST_EMIT_END;
                        end
                    end else if (!r_have_first) begin
                        n_have_first = 1'b1;
                        n_first      = i_beat.vtx;
                        n_prev       = i_beat.vtx;
                    end else begin
                        n_a       = r_prev;
                        n_b       = i_beat.vtx;
                        n_prev    = i_beat.vtx;
                        n_closing = 1'b0;
                        n_state   = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                n_ia = ia;
                n_ib = ib;
                if (ia && ib) begin
                    n_state = ST_EMIT_B;
                end else if (ia != ib) begin
                    // t = |fa| * 2^16 / |fa - fb|, quotient fits in 17 bits
                    n_rem   = 35'(abs_fa >> 1);
                    n_num   = {abs_fa[0], 16'b0};
                    n_den   = abs_den;
                    n_q     = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = fin_state;
                end
            end
            ST_DIV: begin
                n_rem  = ge ? 35'(trial - {1'b0, r_den}) : trial[34:0];
                n_num  = {r_num[15:0], 1'b0};
                n_q    = {r_q[15:0], ge};
                n_step = r_step + 5'd1;
                if (r_step == 5'(DIV_STEPS - 1)) begin
                    n_k     = COORD_X;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = mul;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                case (r_k)
                    COORD_X: n_p.x = sum;
                    COORD_Y: n_p.y = sum;
                    COORD_Z: n_p.z = sum;
                    default: n_p.w = sum;
                endcase
                if (r_k == COORD_W) begin
                    n_state = ST_EMIT_P;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_MUL;
                end
            end
            ST_EMIT_P: begin
                if (slot_free) begin
                    if (r_cnt_out < CNT_W'(MAX_POLY_VERTICES)) begin
                        n_ovalid  = 1'b1;
                        n_obeat   = '{vtx: r_p, is_end: 1'b0, drop: 1'b0};
                        n_cnt_out = r_cnt_out + 1'b1;
                    end
                    n_state = (!r_ia && r_ib) ? ST_EMIT_B : fin_state;
                end
            end
            ST_EMIT_B: begin
                if (slot_free) begin
                    if (r_cnt_out < CNT_W'(MAX_POLY_VERTICES)) begin
                        n_ovalid  = 1'b1;
                        n_obeat   = '{vtx: r_b, is_end: 1'b0, drop: 1'b0};
                        n_cnt_out = r_cnt_out + 1'b1;
                    end
                    n_state = fin_state;
                end
            end
            ST_EMIT_END: begin
                if (slot_free) begin
                    n_ovalid     = 1'b1;
                    n_obeat      = '{vtx: '0, is_end: 1'b1,
                                     drop: r_drop_in || (r_cnt_out < CNT_W'(MIN_POLY))};
                    n_cnt_out    = '0;
                    n_have_first = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_have_first <= 1'b0;
            r_cnt_out    <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_have_first <= n_have_first;
            r_cnt_out    <= n_cnt_out;
            r_ovalid     <= n_ovalid;
        end
        r_first   <= n_first;
        r_prev    <= n_prev;
        r_a       <= n_a;
        r_b       <= n_b;
        r_p       <= n_p;
        r_closing <= n_closing;
        r_drop_in <= n_drop_in;
        r_ia      <= n_ia;
        r_ib      <= n_ib;
        r_rem     <= n_rem;
        r_num     <= n_num;
        r_den     <= n_den;
        r_q       <= n_q;
        r_step    <= n_step;
        r_k       <= n_k;
        r_prod    <= n_prod;
        r_obeat   <= n_obeat;
    end

endmodule

`default_nettype wire

@@ rtl/ctf_fan_out.sv @@
// Collects the clipped polygon and sends it out as a triangle fan, one vertex per beat.
`default_nettype none

module ctf_fan_out import ctf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_beat    i_beat,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vtx_out o_data
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    t_vtx             r_buf [MAX_POLY_VERTICES];
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_tri, n_tri;
    logic [1:0]       r_corner, n_corner;
    logic             r_ovalid, n_ovalid;
    t_vtx             r_ovtx;
    logic [1:0]       r_ocorner, n_ocorner;
    logic             r_olast, n_olast;

    logic             slot_free;
    logic             wr_en;
    logic             ld_vtx;
    logic [CNT_W-1:0] idx;
    logic             is_last;

    assign o_stall = (r_state != ST_COLLECT);
    assign o_valid = r_ovalid;
    assign o_data  = '{out_x: r_ovtx.x, out_y: r_ovtx.y, out_z: r_ovtx.z, out_w: r_ovtx.w,
                       corner: r_ocorner, last_of_run: r_olast};

    always_comb begin
        slot_free = !r_ovalid || !i_stall;
        wr_en     = (r_state == ST_COLLECT) && i_valid && !i_beat.is_end
                    && (r_cnt < CNT_W'(MAX_POLY_VERTICES));
        ld_vtx    = (r_state == ST_EMIT) && slot_free;
        idx       = (r_corner == CORNER_0) ? '0 : (r_tri + CNT_W'(r_corner));
        is_last   = (r_corner == CORNER_2) && (r_tri == r_cnt - CNT_W'(MIN_POLY));

        n_state   = r_state;
        n_cnt     = r_cnt;
        n_tri     = r_tri;
        n_corner  = r_corner;
        n_ovalid  = r_ovalid && i_stall;
        n_ocorner = r_ocorner;
        n_olast   = r_olast;

        case (r_state)
            ST_COLLECT: begin
                if (i_valid) begin
                    if (!i_beat.is_end) begin
                        if (wr_en) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (i_beat.drop || (r_cnt < CNT_W'(MIN_POLY))) begin
                        n_cnt = '0;
                    end else begin
                        n_tri    = '0;
                        n_corner = CORNER_0;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ocorner = r_corner;
                    n_olast   = is_last;
                    if (r_corner == CORNER_2) begin
                        n_corner = CORNER_0;
                        n_tri    = r_tri + 1'b1;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                    if (is_last) begin
                        n_cnt   = '0;
                        n_state = ST_COLLECT;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_beat.vtx;
        end
        if (ld_vtx) begin
            r_ovtx <= r_buf[idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COLLECT;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_tri     <= n_tri;
        r_corner  <= n_corner;
        r_ocorner <= n_ocorner;
        r_olast   <= n_olast;
    end

endmodule

`default_nettype wire

@@ rtl/clip_triangle_to_frustum.sv @@
// Top level: triangle feeder, six plane cells in a row, fan triangulation output.
//
// Input channel: one beat carries a whole triangle (three Q16.16 clip-space
// vertices). Output channel: one beat per vertex of an output triangle, with
// corner 0..2 and last_of_run on the final vertex of the run. A triangle that
// is clipped away entirely produces no beats.
// The triangle is fed as three vertex beats and an end marker into a chain of
// six plane cells (-x, +x, -y, +y, -z, +z). Each cell clips the vertex stream
// against its plane; for a crossing edge it runs a 17-step restoring divider
// for t, then one multiply and one add per coord, before it emits.
// The input stays stalled until the first cell has taken all four beats.
// Triangles overlap in the chain; sustained rate is set by the busiest cell.
// Reset (synchronous, active low) empties every cell and drops any beats in
// flight. When the receiver stalls, the output register holds its beat and
// back-pressure propagates cell by cell up to o_in_stall.
`default_nettype none

module clip_triangle_to_frustum import ctf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_tri_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_vtx_out o_out_data
);

    logic    r_feeding;
    logic [1:0] r_feed_idx;
    t_tri_in r_tri;

    logic  w_valid [PLANE_COUNT+1];
    logic  w_stall [PLANE_COUNT+1];
    t_beat w_beat  [PLANE_COUNT+1];

    assign o_in_stall = r_feeding;
    assign w_valid[0] = r_feeding;

    always_comb begin
        case (r_feed_idx)
            2'd0: w_beat[0] = '{vtx: '{x: r_tri.ax, y: r_tri.ay, z: r_tri.az, w: r_tri.aw},
                                is_end: 1'b0, drop: 1'b0};
            2'd1: w_beat[0] = '{vtx: '{x: r_tri.bx, y: r_tri.by_coord, z: r_tri.bz,
                                       w: r_tri.bw},
                                is_end: 1'b0, drop: 1'b0};
            2'd2: w_beat[0] = '{vtx: '{x: r_tri.cx, y: r_tri.cy, z: r_tri.cz, w: r_tri.cw},
                                is_end: 1'b0, drop: 1'b0};
            default: w_beat[0] = '{vtx: '0, is_end: 1'b1, drop: 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feeding  <= 1'b0;
            r_feed_idx <= '0;
        end else if (!r_feeding) begin
            if (i_in_valid) begin
                r_feeding  <= 1'b1;
                r_feed_idx <= '0;
            end
        end else if (!w_stall[0]) begin
            r_feed_idx <= r_feed_idx + 2'd1;
            if (r_feed_idx == 2'd3) begin
                r_feeding <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_feeding && i_in_valid) begin
            r_tri <= i_in_data;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        ctf_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (3'(g)),
            .i_valid (w_valid[g]),
            .o_stall (w_stall[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .i_stall (w_stall[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    ctf_fan_out u_fan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[PLANE_COUNT]),
        .o_stall (w_stall[PLANE_COUNT]),
        .i_beat  (w_beat[PLANE_COUNT]),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ rtl/ctf_checker.sv @@
// Port-level checks for the frustum clipper, bound to the top level.
`default_nettype none

module ctf_checker import ctf_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_tri_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_vtx_out o_out_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    a_corner_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.corner == CORNER_0 || o_out_data.corner == CORNER_1
                         || o_out_data.corner == CORNER_2))
        else $error("corner out of range");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_of_run |-> o_out_data.corner == CORNER_2)
        else $error("last_of_run on a vertex that does not close a triangle");

    a_feed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous triangle still being fed");

endmodule

bind clip_triangle_to_frustum ctf_checker u_ctf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ verif/clip_triangle_to_frustum_check.sv @@
// Checker for the frustum triangle clipper: watches both channels, predicts and compares.
module clip_triangle_to_frustum_check import ctf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_tri_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_vtx_out i_out_data,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint c[4];
    } t_pt;

    t_vtx_out expected_vertices[$];

    assign o_pending = expected_vertices.size();

    function automatic longint side_fn(t_pt v, int p);
        longint c;
        c = v.c[(p >> 1) & 3];
        return ((p & 1) == 0) ? c + v.c[3] : c - v.c[3];
    endfunction

    function automatic bit is_in(t_pt v, int p);
        longint f;
        f = side_fn(v, p);
        return ((p & 1) == 0) ? (f >= 0) : (f <= 0);
    endfunction

    function automatic t_pt edge_cut(t_pt a, t_pt b, int p);
        t_pt r;
        longint fa, fb, den, t;
        fa = side_fn(a, p);
        fb = side_fn(b, p);
        den = fa - fb;
        t = 0;
        if (den != 0) t = (fa * 65536) / den;
        for (int k = 0; k < 4; k++) r.c[k] = a.c[k] + ((b.c[k] - a.c[k]) * t) / 65536;
        return r;
    endfunction

    task automatic predict_clip(t_tri_in d);
        t_pt src[$];
        t_pt dst[$];
        t_pt a, b, q, v;
        int ntri;
        t_vtx_out o;
        v.c[0] = longint'(d.ax); v.c[1] = longint'(d.ay);
        v.c[2] = longint'(d.az); v.c[3] = longint'(d.aw);
        src = {src, v};
        v.c[0] = longint'(d.bx); v.c[1] = longint'(d.by_coord);
        v.c[2] = longint'(d.bz); v.c[3] = longint'(d.bw);
        src = {src, v};
        v.c[0] = longint'(d.cx); v.c[1] = longint'(d.cy);
        v.c[2] = longint'(d.cz); v.c[3] = longint'(d.cw);
        src = {src, v};
        for (int p = 0; p < PLANE_COUNT; p++) begin
            dst.delete();
            for (int i = 0; i < src.size(); i++) begin
                a = src[i];
                b = src[(i + 1 < src.size()) ? i + 1 : 0];
                if (is_in(a, p) && is_in(b, p)) begin
                    if (dst.size() < MAX_POLY_VERTICES) dst = {dst, b};
                end else if (is_in(a, p) != is_in(b, p)) begin
                    q = edge_cut(a, b, p);
                    if (dst.size() < MAX_POLY_VERTICES) dst = {dst, q};
                    if (!is_in(a, p) && dst.size() < MAX_POLY_VERTICES) dst = {dst, b};
                end
            end
            if (dst.size() < MIN_POLY) return;
            src = dst;
        end
        ntri = src.size() - 2;
        if (ntri > 7) ntri = 7;
        for (int i = 0; i < ntri; i++) begin
            for (int j = 0; j < 3; j++) begin
                v = (j == 0) ? src[0] : src[i + j];
                o.out_x = 32'(v.c[0]); o.out_y = 32'(v.c[1]);
                o.out_z = 32'(v.c[2]); o.out_w = 32'(v.c[3]);
                o.corner = j[1:0];
                o.last_of_run = (i == ntri - 1) && (j == 2);
                expected_vertices = {expected_vertices, o};
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_vtx_out e;
        if (!i_rst_n) o_fail_count = 0;
        if (i_rst_n && i_in_valid && !i_in_stall) predict_clip(i_in_data);
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_vertices.size() == 0) begin
                report_mismatch("unexpected beat", longint'(i_out_data.out_x), 0);
            end else begin
                e = expected_vertices.pop_front();
                if (i_out_data.out_x !== e.out_x)
                    report_mismatch("x", longint'(i_out_data.out_x), longint'(e.out_x));
                if (i_out_data.out_y !== e.out_y)
                    report_mismatch("y", longint'(i_out_data.out_y), longint'(e.out_y));
                if (i_out_data.out_z !== e.out_z)
                    report_mismatch("z", longint'(i_out_data.out_z), longint'(e.out_z));
                if (i_out_data.out_w !== e.out_w)
                    report_mismatch("w", longint'(i_out_data.out_w), longint'(e.out_w));
                if (i_out_data.corner !== e.corner)
                    report_mismatch("corner", longint'(i_out_data.corner),
                                    longint'(e.corner));
                if (i_out_data.last_of_run !== e.last_of_run)
                    report_mismatch("last", longint'(i_out_data.last_of_run),
                                    longint'(e.last_of_run));
            end
        end
    end
endmodule

@@ verif/clip_triangle_to_frustum_test.sv @@
// Testbench top for the frustum triangle clipper: stimulus, idling phases and verdict.
module clip_triangle_to_frustum_test;
    import ctf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_tri_in  in_data;
    logic     out_valid;
    logic     out_stall;
    t_vtx_out out_data;
    int       fail_count;
    int       pending;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_off;
    int       cycle_count;

    localparam int CYCLE_LIMIT = 600000;

    clip_triangle_to_frustum dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    clip_triangle_to_frustum_check checker_inst (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_coord(int mode);
        case ($urandom_range(mode == 0 ? 9 : 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom;
            default: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
        endcase
    endfunction

    task automatic send_tri(t_tri_in d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_coords(logic signed [31:0] v[12]);
        t_tri_in d;
        d = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        send_tri(d);
    endtask

    task automatic send_random(int mode);
        logic signed [31:0] v[12];
        for (int i = 0; i < 12; i++) v[i] = pick_coord(mode);
        for (int i = 3; i < 12; i += 4) begin
            if ($urandom_range(3) != 0) v[i] = $urandom_range(32'h0010_0000, 32'h0000_8000);
        end
        send_coords(v);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        logic signed [31:0] v[12];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fully inside
        v = '{32'sh8000, 0, 0, 32'sh10000, 0, 32'sh8000, 0, 32'sh10000,
              -32'sh8000, -32'sh8000, 32'sh4000, 32'sh10000};
        send_coords(v);
        // on the boundary planes
        v = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000, 0, 0, 32'sh10000,
              0, -32'sh10000, -32'sh10000, 32'sh10000};
        send_coords(v);
        // large triangle cut by all planes
        v = '{-32'sh40000, -32'sh40000, 32'sh30000, 32'sh10000, 32'sh40000, -32'sh40000,
              -32'sh30000, 32'sh10000, 0, 32'sh50000, 0, 32'sh10000};
        send_coords(v);
        // fully outside, behind w
        v = '{0, 0, 0, -32'sh10000, 1, 1, 1, -32'sh10000, 2, 2, 2, -32'sh10000};
        send_coords(v);
        // extremes
        v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
              0, 0, 0, 32'sh7fff_ffff};
        send_coords(v);
        v = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              -1, -1, -1, -1};
        send_coords(v);
        // degenerate: all vertices equal
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_coords(v);
        // one vertex outside on +x
        v = '{32'sh30000, 0, 0, 32'sh10000, 0, 32'sh8000, 0, 32'sh10000,
              0, -32'sh8000, 0, 32'sh10000};
        send_coords(v);
        repeat (14) send_random(0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 65) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 65) : 0;
            repeat (22) send_random($urandom_range(1));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // long receiver hold-off while the sender keeps offering triangles
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (12) send_random(1);
        join
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
